[src/mctb_pkg.sv]
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared types and constants for the millisecond timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

  localparam int TIMERS     = 8;
  localparam int IDX_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int MAX_EVENTS = 8;
  localparam int CNT_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int TIME_W     = 32;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic emit;
    logic status_load;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic last_event;
    logic out_free;
  } dp_sts_t;

endpackage

[src/multi_channel_ms_timer_bank.sv]
// ----------------------------------------------------------------------------
// multi_channel_ms_timer_bank
// Bank of millisecond timers with start, stop, status and tick requests;
// a tick reports expired channels in deadline order.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | cmd, channel, now_ms, period,
//           |           |                      | auto_reload
//   out     | output    | out_valid / out_ready| timer_id, kind, is_running,
//           |           |                      | has_timed_out, was_reloaded, last
//
// start and stop complete on acceptance; a status query waits out any stall.
// a tick runs one scan pass per expiry event, or one pass when none expires;
// a pass compares the TIMERS channels in turn and ends in a select state, each
// expiry adds an emit state, and a finish state closes the tick.
// reset clears all channels and the previous clock value; no clearing pass.
// an expiry waits in place while the output register is still occupied.
// ----------------------------------------------------------------------------
module multi_channel_ms_timer_bank import mctb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [2:0]        channel_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] period_i,
  input  logic              auto_reload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        timer_id_o,
  output logic              kind_o,
  output logic              is_running_o,
  output logic              has_timed_out_o,
  output logic              was_reloaded_o,
  output logic              last_o
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  mctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mctb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .channel_i       (channel_i),
    .now_ms_i        (now_ms_i),
    .period_i        (period_i),
    .auto_reload_i   (auto_reload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .timer_id_o      (timer_id_o),
    .kind_o          (kind_o),
    .is_running_o    (is_running_o),
    .has_timed_out_o (has_timed_out_o),
    .was_reloaded_o  (was_reloaded_o),
    .last_o          (last_o)
  );

endmodule

[src/mctb_ctrl.sv]
// ----------------------------------------------------------------------------
// mctb_ctrl
// Sequencer for the timer bank: request intake, deadline scan passes,
// expiry emission and status answers.
// ----------------------------------------------------------------------------
module mctb_ctrl import mctb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  dp_sts_t    sts_i,
  output ctl_cmd_t   ctl_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_EMIT = 6'b001000,
    ST_STAT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (cmd_i)
            CMD_TICK:   state_d = ST_SCAN;
            CMD_STATUS: state_d = ST_STAT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        state_d = sts_i.found ? ST_EMIT : ST_FIN;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = sts_i.last_event ? ST_FIN : ST_SCAN;
        end
      end
      ST_STAT: begin
        if (sts_i.out_free) begin
          ctl_o.status_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_FIN: begin
        ctl_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/mctb_dp.sv]
// ----------------------------------------------------------------------------
// mctb_dp
// Timer state, deadline scan unit and result register of the timer bank.
// ----------------------------------------------------------------------------
module mctb_dp import mctb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_cmd_t          ctl_i,
  output dp_sts_t           sts_o,
  input  logic [1:0]        cmd_i,
  input  logic [2:0]        channel_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] period_i,
  input  logic              auto_reload_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        timer_id_o,
  output logic              kind_o,
  output logic              is_running_o,
  output logic              has_timed_out_o,
  output logic              was_reloaded_o,
  output logic              last_o
);

  logic [TIME_W-1:0] deadline_q [TIMERS];
  logic [TIME_W-1:0] period_q   [TIMERS];
  logic [TIMERS-1:0] wait_wrap_q, active_q, expired_q, mode_q, fire_q;
  logic [TIME_W-1:0] prev_time_q, now_q, best_dl_q;
  logic              wrapped_q, first_q, found_q;
  logic [IDX_W-1:0]  idx_q, best_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [2:0]        chan_q;
  logic              out_valid_q;

  logic [IDX_W-1:0]  ch_idx;
  logic              ch_ok;
  logic [TIME_W-1:0] dl_cur;
  logic              cand_fire, take;
  logic [TIMERS-1:0] best_oh, fire_rest;
  logic [TIME_W:0]   start_sum, arm_sum;
  logic              st_ok, st_run, st_tout;

  assign ch_idx    = channel_i[IDX_W-1:0];
  assign ch_ok     = (int'(channel_i) < TIMERS);
  assign dl_cur    = deadline_q[idx_q];
  assign cand_fire = first_q ? (active_q[idx_q] & ~wait_wrap_q[idx_q] &
                                (wrapped_q | (dl_cur <= now_q)))
                             : fire_q[idx_q];
  assign take      = cand_fire & (~found_q | (dl_cur < best_dl_q));
  assign best_oh   = {{(TIMERS-1){1'b0}}, 1'b1} << best_q;
  assign fire_rest = fire_q & ~best_oh;
  assign start_sum = {1'b0, now_ms_i} + {1'b0, period_i};
  assign arm_sum   = {1'b0, now_q} + {1'b0, period_q[best_q]};

  assign st_ok   = (int'(chan_q) < TIMERS);
  assign st_run  = st_ok & active_q[chan_q[IDX_W-1:0]];
  assign st_tout = st_ok & expired_q[chan_q[IDX_W-1:0]];

  assign sts_o.scan_last  = (idx_q == IDX_W'(TIMERS - 1));
  assign sts_o.found      = found_q;
  assign sts_o.last_event = (fire_rest == '0) || (cnt_q == CNT_W'(MAX_EVENTS - 1));
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o      = out_valid_q;

  // deadline and period storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && cmd_i == CMD_START && ch_ok) begin
      deadline_q[ch_idx] <= start_sum[TIME_W-1:0];
      period_q[ch_idx]   <= period_i;
    end else if (ctl_i.emit && mode_q[best_q]) begin
      deadline_q[best_q] <= arm_sum[TIME_W-1:0];
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      chan_q <= channel_i;
      if (cmd_i == CMD_TICK) begin
        now_q <= now_ms_i;
      end
    end
    if (ctl_i.scan_step && take) begin
      best_q    <= idx_q;
      best_dl_q <= dl_cur;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      timer_id_o      <= 3'(best_q);
      kind_o          <= KIND_EXPIRY;
      is_running_o    <= mode_q[best_q];
      has_timed_out_o <= ~mode_q[best_q];
      was_reloaded_o  <= mode_q[best_q];
      last_o          <= sts_o.last_event;
    end else if (ctl_i.status_load) begin
      timer_id_o      <= chan_q;
      kind_o          <= KIND_STATUS;
      is_running_o    <= st_run;
      has_timed_out_o <= st_tout;
      was_reloaded_o  <= 1'b0;
      last_o          <= 1'b1;
    end
  end

  // timer flags and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_wrap_q <= '0;
      active_q    <= '0;
      expired_q   <= '0;
      mode_q      <= '0;
      fire_q      <= '0;
      prev_time_q <= '0;
      wrapped_q   <= 1'b0;
      first_q     <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.accept) begin
        case (cmd_i)
          CMD_START: begin
            if (ch_ok) begin
              mode_q[ch_idx]      <= auto_reload_i;
              wait_wrap_q[ch_idx] <= start_sum[TIME_W];
              active_q[ch_idx]    <= 1'b1;
              expired_q[ch_idx]   <= 1'b0;
            end
          end
          CMD_STOP: begin
            if (ch_ok) begin
              wait_wrap_q[ch_idx] <= 1'b0;
              active_q[ch_idx]    <= 1'b0;
              expired_q[ch_idx]   <= 1'b0;
            end
          end
          CMD_TICK: begin
            wrapped_q   <= (prev_time_q > now_ms_i);
            prev_time_q <= now_ms_i;
            idx_q       <= '0;
            first_q     <= 1'b1;
            found_q     <= 1'b0;
            cnt_q       <= '0;
          end
          default: ;
        endcase
      end

      if (ctl_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (first_q) begin
          fire_q[idx_q] <= cand_fire;
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end

      if (ctl_i.emit) begin
        fire_q  <= fire_rest;
        idx_q   <= '0;
        first_q <= 1'b0;
        found_q <= 1'b0;
        cnt_q   <= cnt_q + 1'b1;
        if (mode_q[best_q]) begin
          wait_wrap_q[best_q] <= arm_sum[TIME_W];
          active_q[best_q]    <= 1'b1;
          expired_q[best_q]   <= 1'b0;
        end else begin
          active_q[best_q]  <= 1'b0;
          expired_q[best_q] <= 1'b1;
        end
      end

      if (ctl_i.finish && wrapped_q) begin
        wait_wrap_q <= '0;
      end

      if (ctl_i.emit || ctl_i.status_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
